### design/pngcrc_pkg.sv
// ----------------------------------------------------------------------------
// pngcrc_pkg
// Shared types, codes and the CRC-32 byte fold for the PNG chunk framer.
// ----------------------------------------------------------------------------
package pngcrc_pkg;

    localparam int LEN_W   = 31;
    localparam int TYPE_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 32;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [1:0] OP_ERR   = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;

    // One queued request for the back end. For a data request the byte sits
    // in the low bits of ctype. The flag marks a zero-length begin or the
    // final data byte of a chunk; both are followed by the CRC bytes.
    typedef struct packed {
        logic [1:0]        op;
        logic              flag;
        logic [LEN_W-1:0]  length;
        logic [TYPE_W-1:0] ctype;
    } job_t;

    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] c_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = c_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
                c = CRC_POLY ^ (c >> 1);
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] word_byte(input logic [31:0] w,
                                                    input logic [1:0] idx);
        logic [BYTE_W-1:0] r;
        unique case (idx)
            2'd3:    r = w[31:24];
            2'd2:    r = w[23:16];
            2'd1:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

endpackage

### design/pngcrc_in_if.sv
// ----------------------------------------------------------------------------
// pngcrc_in_if
// Request channel of the PNG chunk framer: begin and data commands.
// ----------------------------------------------------------------------------
interface pngcrc_in_if
    import pngcrc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [LEN_W-1:0]  chunk_length;
    logic [TYPE_W-1:0] chunk_type;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, command, chunk_length, chunk_type, data_byte,
                    input ready);
    modport sink   (input valid, command, chunk_length, chunk_type, data_byte,
                    output ready);
endinterface

### design/pngcrc_out_if.sv
// ----------------------------------------------------------------------------
// pngcrc_out_if
// Result channel of the PNG chunk framer: one stream byte per transfer.
// ----------------------------------------------------------------------------
interface pngcrc_out_if
    import pngcrc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              chunk_end;
    logic              run_last;
    logic              protocol_error;

    modport source (output valid, out_byte, chunk_end, run_last, protocol_error,
                    input ready);
    modport sink   (input valid, out_byte, chunk_end, run_last, protocol_error,
                    output ready);
endinterface

### design/pngcrc_front.sv
// ----------------------------------------------------------------------------
// pngcrc_front
// Accepts commands, tracks the open chunk and queues one job per request.
// ----------------------------------------------------------------------------
module pngcrc_front
    import pngcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pngcrc_in_if.sink   cmd,
    input  logic        q_full,
    output logic        push,
    output job_t        push_job
);

    logic             open_reg;
    logic             open_next;
    logic [LEN_W-1:0] remaining_reg;
    logic [LEN_W-1:0] remaining_next;
    logic             accept;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && !q_full;
    assign push      = accept;

    always_comb
    begin
        open_next       = open_reg;
        remaining_next  = remaining_reg;
        push_job.op     = OP_ERR;
        push_job.flag   = 1'b0;
        push_job.length = cmd.chunk_length;
        push_job.ctype  = cmd.chunk_type;
        if (cmd.command == CMD_BEGIN)
        begin
            if (!open_reg)
            begin
                push_job.op   = OP_BEGIN;
                push_job.flag = (cmd.chunk_length == '0);
                if (accept && cmd.chunk_length != '0)
                begin
                    open_next      = 1'b1;
                    remaining_next = cmd.chunk_length;
                end
            end
        end
        else
        begin
            push_job.ctype = {{(TYPE_W-BYTE_W){1'b0}}, cmd.data_byte};
            if (open_reg)
            begin
                push_job.op   = OP_DATA;
                push_job.flag = (remaining_reg == LEN_W'(1));
                if (accept)
                begin
                    remaining_next = remaining_reg - LEN_W'(1);
                    if (remaining_reg == LEN_W'(1))
                        open_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            remaining_reg <= '0;
        end
        else
        begin
            open_reg      <= open_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

### design/pngcrc_queue.sv
// ----------------------------------------------------------------------------
// pngcrc_queue
// Short job queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module pngcrc_queue
    import pngcrc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t              slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_next;
    logic [Q_AW:0]     count_reg;
    logic [Q_AW:0]     count_next;

    assign full       = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/pngcrc_back.sv
// ----------------------------------------------------------------------------
// pngcrc_back
// Byte sequencer: expands each job into stream bytes, runs the CRC-32 and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module pngcrc_back
    import pngcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  job_t        head_job,
    output logic        pop,
    pngcrc_out_if.source res
);

    localparam logic [3:0] STEP_TYPE0      = 4'd4;
    localparam logic [3:0] STEP_TYPE3      = 4'd7;
    localparam logic [3:0] STEP_BEGIN_LAST = 4'd11;
    localparam logic [3:0] STEP_DATA_LAST  = 4'd4;

    logic [3:0]        step_reg;
    logic [3:0]        step_next;
    logic [CRC_W-1:0]  crc_reg;
    logic [CRC_W-1:0]  crc_next;
    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              end_reg;
    logic              last_reg;
    logic              err_reg;

    logic              advance;
    logic              is_final;
    logic [BYTE_W-1:0] cur_byte;
    logic [CRC_W-1:0]  crc_out;
    logic [CRC_W-1:0]  crc_base;

    assign advance = head_valid && (!valid_reg || res.ready);
    assign crc_out = crc_reg ^ CRC_PRESET;

    always_comb
    begin
        is_final = 1'b0;
        cur_byte = '0;
        crc_base = crc_reg;
        crc_next = crc_reg;
        unique case (head_job.op)
            OP_BEGIN:
            begin
                is_final = head_job.flag ? (step_reg == STEP_BEGIN_LAST)
                                         : (step_reg == STEP_TYPE3);
                if (step_reg < STEP_TYPE0)
                    cur_byte = word_byte({1'b0, head_job.length}, 2'd3 - step_reg[1:0]);
                else if (step_reg <= STEP_TYPE3)
                begin
                    cur_byte = word_byte(head_job.ctype, 2'd3 - step_reg[1:0]);
                    if (step_reg == STEP_TYPE0)
                        crc_base = CRC_PRESET;
                    crc_next = crc_fold(crc_base, cur_byte);
                end
                else
                    cur_byte = word_byte(crc_out, 2'd3 - step_reg[1:0]);
            end
            OP_DATA:
            begin
                is_final = head_job.flag ? (step_reg == STEP_DATA_LAST)
                                         : (step_reg == 4'd0);
                if (step_reg == 4'd0)
                begin
                    cur_byte = head_job.ctype[BYTE_W-1:0];
                    crc_next = crc_fold(crc_reg, cur_byte);
                end
                else
                    cur_byte = word_byte(crc_out, 2'd0 - step_reg[1:0]);
            end
            default:
            begin
                is_final = 1'b1;
            end
        endcase
    end

    assign pop = advance && is_final;

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            step_next  = is_final ? 4'd0 : step_reg + 4'd1;
        end
        else if (res.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            crc_reg   <= CRC_PRESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
            if (advance)
                crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= cur_byte;
            end_reg  <= is_final && head_job.flag && (head_job.op != OP_ERR);
            last_reg <= is_final;
            err_reg  <= (head_job.op == OP_ERR);
        end
    end

    assign res.valid          = valid_reg;
    assign res.out_byte       = byte_reg;
    assign res.chunk_end      = end_reg;
    assign res.run_last       = last_reg;
    assign res.protocol_error = err_reg;

endmodule

### design/png_chunk_framer_crc32_unit.sv
// ----------------------------------------------------------------------------
// png_chunk_framer_crc32_unit
// Frames PNG chunks as a byte stream: length, type, data and CRC-32.
//
//   Channel  Role    Carries
//   cmd      sink    begin (length, type) or one data byte per request
//   res      source  one stream byte with end, last and error marks
//
// Each accepted request yields its bytes at one per cycle unless res stalls:
// one for a data byte, eight for a begin (twelve for an empty chunk), five
// for the final data byte. The byte sequencer and its output register set
// that rate; a four-entry job queue lets requests arrive while a header or
// CRC is out. Reset clears the queue, the chunk state and output valid at
// once. A stall on res holds the output and backs up into the queue, then cmd.
// ----------------------------------------------------------------------------
module png_chunk_framer_crc32_unit
    import pngcrc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pngcrc_in_if.sink    cmd,
    pngcrc_out_if.source res
);

    logic q_full;
    logic push;
    job_t push_job;
    logic pop;
    logic head_valid;
    job_t head_job;

    pngcrc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    pngcrc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    pngcrc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .res        (res)
    );

endmodule

### design/pngcrc_checker.sv
// ----------------------------------------------------------------------------
// pngcrc_checker
// Port-level checks of the PNG chunk framer result stream.
// ----------------------------------------------------------------------------
module pngcrc_checker
    import pngcrc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic [BYTE_W-1:0] res_byte,
    input logic              res_end,
    input logic              res_last,
    input logic              res_err
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_byte))
        else $error("result changed while stalled");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_end |-> res_last && !res_err)
        else $error("chunk end not on the last result of a request");

    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_err |-> res_last && !res_end && res_byte == '0)
        else $error("malformed error result");

endmodule

bind png_chunk_framer_crc32_unit pngcrc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_byte  (res.out_byte),
    .res_end   (res.chunk_end),
    .res_last  (res.run_last),
    .res_err   (res.protocol_error)
);

### tb/chunk_stream_predictor.sv
// ----------------------------------------------------------------------------
// chunk_stream_predictor
// Watches both channels of the PNG chunk framer. Every accepted request is
// run through a local model of the framer state and its CRC-32, and the
// stream bytes it should produce are queued. Every accepted result byte is
// compared field by field with the oldest queued byte.
// ----------------------------------------------------------------------------
module chunk_stream_predictor
    import pngcrc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    pngcrc_in_if   req_ch,
    pngcrc_out_if  res_ch,
    output int     backlog,
    output int     mismatches
);

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
        logic              ends_chunk;
        logic              last_of_req;
        logic              error_mark;
    } framed_byte_t;

    framed_byte_t     pending_bytes[$];
    logic [CRC_W-1:0] crc_acc;
    logic [LEN_W-1:0] bytes_left;
    logic             in_chunk;

    function automatic logic [CRC_W-1:0] crc_byte_step(input logic [CRC_W-1:0] c_in,
                                                       input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = c_in ^ {24'd0, b};
        repeat (8)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic ends, input logic err);
        framed_byte_t fb;
        fb.stream_byte = b;
        fb.ends_chunk  = ends;
        fb.last_of_req = 1'b0;
        fb.error_mark  = err;
        pending_bytes.push_back(fb);
    endtask

    task automatic queue_word(input logic [31:0] w, input logic mark_end);
        for (int i = 3; i >= 0; i--)
        begin
            queue_byte(w[8*i +: 8], mark_end && (i == 0), 1'b0);
        end
    endtask

    task automatic close_chunk();
        queue_word(crc_acc ^ CRC_PRESET, 1'b1);
        in_chunk   = 1'b0;
        bytes_left = '0;
    endtask

    task automatic predict_request(input logic command,
                                   input logic [LEN_W-1:0] len,
                                   input logic [TYPE_W-1:0] ctype,
                                   input logic [BYTE_W-1:0] db);
        framed_byte_t tail;
        if (command == CMD_BEGIN)
        begin
            if (in_chunk)
            begin
                queue_byte(8'd0, 1'b0, 1'b1);
            end
            else
            begin
                queue_word({1'b0, len}, 1'b0);
                queue_word(ctype, 1'b0);
                crc_acc = CRC_PRESET;
                for (int i = 3; i >= 0; i--)
                begin
                    crc_acc = crc_byte_step(crc_acc, ctype[8*i +: 8]);
                end
                if (len == '0)
                begin
                    close_chunk();
                end
                else
                begin
                    bytes_left = len;
                    in_chunk   = 1'b1;
                end
            end
        end
        else
        begin
            if (!in_chunk)
            begin
                queue_byte(8'd0, 1'b0, 1'b1);
            end
            else
            begin
                queue_byte(db, 1'b0, 1'b0);
                crc_acc    = crc_byte_step(crc_acc, db);
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0)
                begin
                    close_chunk();
                end
            end
        end
        tail = pending_bytes.pop_back();
        tail.last_of_req = 1'b1;
        pending_bytes.push_back(tail);
    endtask

    task automatic compare_result();
        framed_byte_t want;
        if (pending_bytes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result byte %02h", res_ch.out_byte));
        end
        else
        begin
            want = pending_bytes.pop_front();
            if (res_ch.out_byte !== want.stream_byte)
                report_mismatch($sformatf("out_byte %02h, expected %02h",
                                          res_ch.out_byte, want.stream_byte));
            if (res_ch.chunk_end !== want.ends_chunk)
                report_mismatch($sformatf("chunk_end %b, expected %b",
                                          res_ch.chunk_end, want.ends_chunk));
            if (res_ch.run_last !== want.last_of_req)
                report_mismatch($sformatf("run_last %b, expected %b",
                                          res_ch.run_last, want.last_of_req));
            if (res_ch.protocol_error !== want.error_mark)
                report_mismatch($sformatf("protocol_error %b, expected %b",
                                          res_ch.protocol_error, want.error_mark));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bytes.delete();
            crc_acc    = CRC_PRESET;
            bytes_left = '0;
            in_chunk   = 1'b0;
            backlog   <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                predict_request(req_ch.command, req_ch.chunk_length,
                                req_ch.chunk_type, req_ch.data_byte);
            if (res_ch.valid && res_ch.ready)
                compare_result();
            backlog <= pending_bytes.size();
        end
    end

endmodule

### tb/png_chunk_framer_crc32_unit_test.sv
// ----------------------------------------------------------------------------
// png_chunk_framer_crc32_unit_test
// Drives begin and data requests into the PNG chunk framer: a directed set of
// empty, short and interleaved chunks with out-of-sequence requests, then
// random chunks with random types and bytes and some stray requests, and
// finally a chunk of the largest length that is left open. Both channels idle
// at random. The stream predictor checks every result byte.
// ----------------------------------------------------------------------------
module png_chunk_framer_crc32_unit_test;
    import pngcrc_pkg::*;

    localparam int RANDOM_REQUESTS = 205;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;

    logic clk;
    logic rst_n;
    int   gap_pct   = 34;
    int   stall_pct = 34;
    int   requests_sent;
    int   backlog;
    int   mismatches;

    pngcrc_in_if  cmd_ch ();
    pngcrc_out_if res_ch ();

    png_chunk_framer_crc32_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    chunk_stream_predictor stream_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_ch     (cmd_ch),
        .res_ch     (res_ch),
        .backlog    (backlog),
        .mismatches (mismatches)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_request(input logic command, input logic [LEN_W-1:0] len,
                                input logic [TYPE_W-1:0] ctype,
                                input logic [BYTE_W-1:0] db);
        while ($urandom_range(99) < gap_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= command;
        cmd_ch.chunk_length <= len;
        cmd_ch.chunk_type   <= ctype;
        cmd_ch.data_byte    <= db;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_begin(input logic [LEN_W-1:0] len, input logic [TYPE_W-1:0] ctype);
        send_request(CMD_BEGIN, len, ctype, BYTE_W'($urandom_range(255)));
    endtask

    task automatic send_data(input logic [BYTE_W-1:0] db);
        logic [31:0] r;
        logic [31:0] t;
        r = $urandom;
        t = $urandom;
        send_request(CMD_DATA, r[LEN_W-1:0], t, db);
    endtask

    task automatic send_random_begin();
        logic [31:0] r;
        r = $urandom;
        send_begin(r[LEN_W-1:0], $urandom);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        wait (backlog == 0);
        @(negedge clk);
    endtask

    initial
    begin
        int          chunk_len;
        int          stop_at;
        bit          paused;
        cmd_ch.valid        = 1'b0;
        cmd_ch.command      = CMD_BEGIN;
        cmd_ch.chunk_length = '0;
        cmd_ch.chunk_type   = '0;
        cmd_ch.data_byte    = '0;
        rst_n               = 1'b0;
        requests_sent       = 0;
        paused              = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_data(8'hFF);
        send_data(8'h00);
        send_begin('0, TYPE_IEND);
        send_begin('0, 32'hFFFF_FFFF);
        send_begin(31'd1, 32'h0000_0000);
        send_data(8'hFF);
        send_begin(31'd3, TYPE_IDAT);
        send_begin(31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_data(8'h00);
        send_data(8'h80);
        send_data(8'h7F);
        send_begin(31'd4, TYPE_TEXT);
        send_data(8'hAA);
        send_data(8'h55);
        send_data(8'h01);
        send_data(8'hFE);
        send_data(8'h3C);
        drain_results();

        stop_at = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < stop_at)
        begin
            if (requests_sent > stop_at - 150 && requests_sent < stop_at - 90)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = 34;
                stall_pct = 34;
            end
            if (!paused && requests_sent > stop_at - 60)
            begin
                paused = 1'b1;
                drain_results();
            end
            if ($urandom_range(99) < 8)
            begin
                send_data(BYTE_W'($urandom_range(255)));
            end
            else
            begin
                chunk_len = ($urandom_range(99) < 80) ? $urandom_range(6)
                                                      : $urandom_range(40, 7);
                send_begin(LEN_W'(chunk_len), $urandom);
                for (int j = 0; j < chunk_len; j++)
                begin
                    if ($urandom_range(99) < 6)
                        send_random_begin();
                    send_data(BYTE_W'($urandom_range(255)));
                end
            end
        end

        send_begin(31'h7FFF_FFFF, $urandom);
        repeat (5) send_data(BYTE_W'($urandom_range(255)));
        send_random_begin();

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
